// ----- hdl/multiset_intersection_matcher_assert.svh -----
// ----------------------------------------------------------------------------
// Multiset intersection matcher assertion macros
// Concurrent assertion wrappers; they compile to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef MULTISET_INTERSECTION_MATCHER_ASSERT_SVH
`define MULTISET_INTERSECTION_MATCHER_ASSERT_SVH

`ifndef SYNTH
// check on every clock edge outside of reset
`define MIM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// check on every clock edge, reset included
`define MIM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MIM_ASSERT(label, clk, rst, prop, msg)
`define MIM_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- hdl/mim_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mim_pkg
// Shared constants and types of the multiset intersection matcher.
// ----------------------------------------------------------------------------
package mim_pkg;

   // store geometry
   localparam int STORE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // field widths
   localparam int VALUE_W = 32;
   localparam int CMD_W   = 2;
   localparam int ENTRY_W = VALUE_W + 1;   // live bit on top of the value

   // command codes; the fourth code is ignored
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_QUERY = 2'd2
   } cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   // one result word
   typedef struct packed {
      logic               full;
      logic               matched;
      logic [VALUE_W-1:0] value;
   } result_type;

endpackage

// ----- hdl/mim_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mim_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mim_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/multiset_intersection_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multiset_intersection_matcher
// Loads a multiset into a RAM and consumes at most one equal live entry per query.
// ----------------------------------------------------------------------------
//  channel  dir  tdata              tuser
//  req      in   value              command
//  rsp      out  matched_value      matched, store_full
//
// Clear and load write their result to res_ff; ST_FINISH then moves it to the
// output register once that register is free. A query scans the RAM one entry
// per cycle from index 0 up to fill_count, stopping at the first live match.
// Reset needs no sweep: entries at or above fill_count are never read.
// A new word is accepted while the previous result waits on rsp_tready.
// ----------------------------------------------------------------------------
`include "multiset_intersection_matcher_assert.svh"

module multiset_intersection_matcher import mim_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // [31:0] value
   input  logic [1:0]   req_tuser,   // [1:0] command
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,   // [31:0] matched_value
   output logic [1:0]   rsp_tuser    // [0] matched, [1] store_full
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [VALUE_W-1:0] key_ff, key_in;
   result_type         res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [ENTRY_W-1:0] ram_wdata;
   logic               ram_re;
   logic [ENTRY_W-1:0] ram_rdata;

   logic               accept;
   logic               store_full;
   logic               hit;
   logic               issue;
   cmd_type            cmd;

   assign cmd        = cmd_type'(req_tuser);
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign store_full = (fill_ff == CNT_W'(STORE_DEPTH));
   assign hit        = rd_valid_ff && ram_rdata[ENTRY_W-1] &&
                       (ram_rdata[VALUE_W-1:0] == key_ff);
   assign issue      = (idx_ff < fill_ff);

   // value store: {live, value}
   mim_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // sequencer: load/clear, scan with read-compare-invalidate, hand-off
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      rd_valid_in  = 1'b0;
      cmp_idx_in   = idx_ff[ADDR_W-1:0];
      key_in       = key_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      ram_waddr    = fill_ff[ADDR_W-1:0];
      ram_wdata    = {1'b1, req_tdata};
      ram_re       = 1'b0;

      // output word taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in   = '0;
               key_in   = req_tdata;
               idx_in   = '0;
               state_in = ST_FINISH;
               case (cmd)
                  CMD_CLEAR: begin
                     fill_in = '0;
                  end
                  CMD_LOAD: begin
                     if (store_full) begin
                        res_in.full = 1'b1;
                     end else begin
                        ram_we  = 1'b1;
                        fill_in = fill_ff + CNT_W'(1);
                     end
                  end
                  CMD_QUERY: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // consume the entry: clear its live bit
               ram_we         = 1'b1;
               ram_waddr      = cmp_idx_ff;
               ram_wdata      = {1'b0, key_ff};
               res_in.matched = 1'b1;
               res_in.value   = key_ff;
               state_in       = ST_FINISH;
            end else if (issue) begin
               ram_re      = 1'b1;
               idx_in      = idx_ff + CNT_W'(1);
               rd_valid_in = 1'b1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      key_ff     <= key_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.value;
   assign rsp_tuser  = {rsp_ff.full, rsp_ff.matched};

   // checks
   `MIM_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_tvalid && req_tready), "not idle after reset")
   `MIM_ASSERT(a_fill_bound, clock, reset, fill_ff <= CNT_W'(STORE_DEPTH), "fill count over depth")
   `MIM_ASSERT(a_scan_bound, clock, reset, (state_ff == ST_SCAN) |-> (idx_ff <= fill_ff), "scan index past fill count")
   `MIM_ASSERT(a_load_grows, clock, reset, (accept && cmd == CMD_LOAD && !store_full) |=> (fill_ff == $past(fill_ff) + CNT_W'(1)), "load did not advance fill count")
   `MIM_ASSERT(a_hit_write, clock, reset, (state_ff == ST_SCAN && hit) |=> (state_ff == ST_FINISH && res_ff.matched), "hit not reported")

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multiset intersection matcher. A short table
// covers the value extremes, every command and the special cases. Random
// sessions of clear, load and query words follow, with one session that fills
// the store past its depth. Results are checked field by field against the
// table or a shadow copy of the store kept in the bench.
// ----------------------------------------------------------------------------
module testbench import mim_pkg::*; ();

   localparam int CLK_HALF     = 1;
   localparam int RESET_CYCLES = 11;
   localparam int ITEM_TARGET  = 750;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 300;       // longest query scan plus margin
   localparam int TIMEOUT_NS   = 2_000_000;
   localparam int PRINT_LIMIT  = 40;
   localparam int DIR_ROWS     = 22;

   // the fourth command code has no name in the package
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
   localparam result_type QUIET = '0;

   // one row of the directed table; want is used only when typed is set
   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [VALUE_W-1:0] val;
      logic               typed;
      result_type         want;
   } directed_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [31:0]        req_tdata = '0;   // [31:0] value
   logic [1:0]         req_tuser = '0;   // [1:0] command
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [31:0]        rsp_tdata;        // [31:0] matched_value
   logic [1:0]         rsp_tuser;        // [0] matched, [1] store_full

   // shadow of the block's store
   logic [VALUE_W-1:0] shadow_values [STORE_DEPTH];
   logic               shadow_live   [STORE_DEPTH];
   int unsigned        shadow_fill;

   result_type         awaited_results [$];
   logic [VALUE_W-1:0] session_values [$];

   int                 error_count = 0;
   int                 meaningful_words = 0;
   int                 words_by_cmd [4] = '{0, 0, 0, 0};
   int                 results_seen = 0;
   int                 matches_seen = 0;
   int                 drops_seen = 0;
   int                 burst_left = 0;
   bit                 hold_off_req = 1'b0;

   directed_row_type directed_rows [DIR_ROWS] = '{
      '{CMD_QUERY,    32'h0000_0000, 1'b1, QUIET},   // query on an empty store
      '{CMD_RESERVED, 32'hFFFF_FFFF, 1'b1, QUIET},   // unused code
      '{CMD_LOAD,     32'h8000_0000, 1'b1, QUIET},
      '{CMD_LOAD,     32'h7FFF_FFFF, 1'b1, QUIET},
      '{CMD_LOAD,     32'h0000_0000, 1'b1, QUIET},
      '{CMD_LOAD,     32'hFFFF_FFFF, 1'b1, QUIET},
      '{CMD_LOAD,     32'h7FFF_FFFF, 1'b1, QUIET},   // duplicate
      '{CMD_QUERY,    32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b1, 32'h7FFF_FFFF}},
      '{CMD_QUERY,    32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b1, 32'h7FFF_FFFF}},
      '{CMD_QUERY,    32'h7FFF_FFFF, 1'b0, QUIET},   // both copies used up
      '{CMD_QUERY,    32'h8000_0000, 1'b1, '{1'b0, 1'b1, 32'h8000_0000}},
      '{CMD_QUERY,    32'h0000_0000, 1'b1, '{1'b0, 1'b1, 32'h0000_0000}},
      '{CMD_QUERY,    32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 32'hFFFF_FFFF}},
      '{CMD_QUERY,    32'hFFFF_FFFF, 1'b0, QUIET},
      '{CMD_RESERVED, 32'h1234_5678, 1'b1, QUIET},   // must not load
      '{CMD_QUERY,    32'h1234_5678, 1'b0, QUIET},
      '{CMD_LOAD,     32'hA5A5_A5A5, 1'b0, QUIET},
      '{CMD_CLEAR,    32'h0000_0000, 1'b1, QUIET},
      '{CMD_QUERY,    32'hA5A5_A5A5, 1'b0, QUIET},   // gone after clear
      '{CMD_LOAD,     32'h5A5A_5A5A, 1'b0, QUIET},
      '{CMD_QUERY,    32'h5A5A_5A5A, 1'b0, QUIET},
      '{CMD_CLEAR,    32'hDEAD_BEEF, 1'b1, QUIET}
   };

   multiset_intersection_matcher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #CLK_HALF clock = ~clock;

   // apply one word to the shadow store and return its result
   function automatic result_type predict_match_result(input logic [CMD_W-1:0] cmd,
                                                       input logic [VALUE_W-1:0] val);
      result_type res;
      int         idx;
      res = '0;
      case (cmd)
         CMD_CLEAR: begin
            for (idx = 0; idx < STORE_DEPTH; idx++) shadow_live[idx] = 1'b0;
            shadow_fill = 0;
         end
         CMD_LOAD: begin
            if (shadow_fill < STORE_DEPTH) begin
               shadow_values[shadow_fill] = val;
               shadow_live[shadow_fill]   = 1'b1;
               shadow_fill++;
            end else begin
               res.full = 1'b1;
            end
         end
         CMD_QUERY: begin
            // lowest live equal entry is consumed
            for (idx = 0; idx < shadow_fill && !res.matched; idx++) begin
               if (shadow_live[idx] && shadow_values[idx] == val) begin
                  shadow_live[idx] = 1'b0;
                  res.matched      = 1'b1;
                  res.value        = val;
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (error_count < PRINT_LIMIT)
         $display("ERROR at %0t ns: %s got %h want %h", $time, what, got, want);
      error_count++;
   endtask

   // offer one word, wait for it to go in, log what should come back
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val,
                            input logic typed, input result_type want);
      result_type predicted;
      int         gap;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_match_result(cmd, val);
      awaited_results.push_back(typed ? want : predicted);
      words_by_cmd[cmd]++;
      if (cmd != CMD_RESERVED) meaningful_words++;
      // bursts of random length, random gaps in between
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
      end
   endtask

   // stop offering and wait until every logged result has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // clear (usually), a few loads, then queries with a few swaps and noise words
   task automatic run_session();
      int                 n_loads;
      int                 n_queries;
      int                 k;
      int                 sel;
      int                 bitpos;
      bit                 is_load;
      logic [VALUE_W-1:0] v;
      if ($urandom_range(0, 99) < 85) begin
         send_word(CMD_CLEAR, $urandom, 1'b0, QUIET);
         session_values.delete();
      end
      n_loads   = $urandom_range(1, 24);
      n_queries = $urandom_range(1, n_loads + 6);
      for (k = 0; k < n_loads + n_queries; k++) begin
         if ($urandom_range(0, 99) < 5) send_word(CMD_RESERVED, $urandom, 1'b0, QUIET);
         is_load = (k < n_loads);
         if ($urandom_range(0, 99) < 15) is_load = !is_load;
         sel = $urandom_range(0, 9);
         if (is_load) begin
            // mix of wide values and a small pool that makes duplicates
            if (sel < 5)      v = $urandom;
            else if (sel < 8) v = $urandom_range(0, 7);
            else              v = 32'hFFFF_FFF8 | $urandom_range(0, 7);
            session_values.push_back(v);
            send_word(CMD_LOAD, v, 1'b0, QUIET);
         end else begin
            if (session_values.size() == 0 || sel >= 8) begin
               v = $urandom;
            end else begin
               v = session_values[$urandom_range(0, session_values.size() - 1)];
               if (sel >= 6) begin
                  // near miss: one bit off a stored value
                  bitpos    = $urandom_range(0, VALUE_W - 1);
                  v[bitpos] = ~v[bitpos];
               end
            end
            send_word(CMD_QUERY, v, 1'b0, QUIET);
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin : rsp_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser[0] === 1'b1) matches_seen++;
         if (rsp_tuser[1] === 1'b1) drops_seen++;
         if (awaited_results.size() == 0) begin
            report_mismatch("word with nothing awaited", rsp_tdata, '0);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_tuser[0] !== want.matched)
               report_mismatch("matched", 32'(rsp_tuser[0]), 32'(want.matched));
            if (rsp_tdata !== want.value)
               report_mismatch("matched_value", rsp_tdata, want.value);
            if (rsp_tuser[1] !== want.full)
               report_mismatch("store_full", 32'(rsp_tuser[1]), 32'(want.full));
         end
      end
   end

   // receiver: changing stall pattern, plus one long hold-off on request
   initial begin : rsp_side
      int stall_mode;
      int mode_left;
      int phase;
      stall_mode = 0;
      mode_left  = 0;
      phase      = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(20, 200);
         end
         mode_left--;
         phase++;
         case (stall_mode)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= 1'($urandom_range(0, 1));
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= (phase % 3 != 0);
         endcase
      end
   end

   // stimulus
   initial begin : req_side
      int r;
      int k;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (r = 0; r < DIR_ROWS; r++)
         send_word(directed_rows[r].cmd, directed_rows[r].val,
                   directed_rows[r].typed, directed_rows[r].want);
      wait_drained();

      while (meaningful_words < 230) run_session();

      // long receiver hold-off while words keep coming
      hold_off_req = 1'b1;
      run_session();
      run_session();
      wait_drained();

      // fill the store past its depth, then query the full store
      send_word(CMD_CLEAR, $urandom, 1'b0, QUIET);
      session_values.delete();
      for (k = 0; k < STORE_DEPTH; k++)
         send_word(CMD_LOAD, $urandom_range(0, 31), 1'b0, QUIET);
      for (k = 0; k < 3; k++)
         send_word(CMD_LOAD, $urandom, 1'b0, QUIET);
      for (k = 0; k < 20; k++)
         send_word(CMD_QUERY, $urandom_range(0, 40), 1'b0, QUIET);
      send_word(CMD_QUERY, $urandom, 1'b0, QUIET);
      // consumed entries keep their slot: still full
      send_word(CMD_LOAD, $urandom, 1'b0, QUIET);
      wait_drained();

      while (meaningful_words < ITEM_TARGET) run_session();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d clear, %0d load, %0d query and %0d unused-code words; %0d checked",
               words_by_cmd[CMD_CLEAR], words_by_cmd[CMD_LOAD], words_by_cmd[CMD_QUERY],
               words_by_cmd[CMD_RESERVED], results_seen);
      $display("Saw %0d matches and %0d loads dropped on a full store; %0d mismatches",
               matches_seen, drops_seen, error_count);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin
      #TIMEOUT_NS;
      $display("Timeout with %0d results still awaited", awaited_results.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
